// ===== sv/cle_pkg.sv =====
// Shared types, constants and helpers for the cursor list engine.
package cle_pkg;

    localparam int NODE_COUNT  = 128;
    localparam int VALUE_WIDTH = 32;
    localparam int NODE_W      = $clog2(NODE_COUNT);
    localparam int STEP_W      = NODE_W + 1;

    typedef logic [NODE_W-1:0]      node_t;
    typedef logic [VALUE_WIDTH-1:0] value_t;
    typedef logic [STEP_W-1:0]      step_t;

    localparam node_t FREE_NODE   = NODE_W'(0);
    localparam node_t HEADER_NODE = NODE_W'(1);
    localparam step_t STEP_LIMIT  = STEP_W'(NODE_COUNT);

    localparam logic [2:0] REQ_INSERT = 3'd0;
    localparam logic [2:0] REQ_REMOVE = 3'd1;
    localparam logic [2:0] REQ_FIND   = 3'd2;
    localparam logic [2:0] REQ_PREV   = 3'd3;
    localparam logic [2:0] REQ_EMPTY  = 3'd4;

    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_POS_ZERO  = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [2:0] req_type;
        logic [31:0] value;
        logic [6:0] position;
    } req_t;

    typedef struct packed {
        logic [6:0] result_node;
        logic       found;
        logic       list_empty;
        logic [6:0] first_node;
        logic [1:0] status;
    } resp_t;

    // One write to the node memory: link and value may be written separately.
    typedef struct packed {
        logic   link_en;
        logic   value_en;
        node_t  addr;
        node_t  link;
        value_t value;
    } node_wr_t;

    // Link held by a node right after reset.
    function automatic node_t link_init(node_t idx);
        node_t r;
        if (idx == FREE_NODE)
            r = NODE_W'(2);
        else if (idx == HEADER_NODE || idx == NODE_W'(NODE_COUNT - 1))
            r = '0;
        else
            r = idx + NODE_W'(1);
        return r;
    endfunction

endpackage

// ===== sv/cle_node_mem.sv =====
// Node memory: link and value arrays, free and list heads kept in registers.
module cle_node_mem
(
    input  logic              clk,
    input  logic              rst_n,
    input  cle_pkg::node_t    rd_addr,
    output cle_pkg::node_t    link_rd,
    output cle_pkg::value_t   value_rd,
    input  cle_pkg::node_wr_t wr,
    output cle_pkg::node_t    free_head,
    output cle_pkg::node_t    first_node
);

    cle_pkg::node_t  link_mem  [cle_pkg::NODE_COUNT];
    cle_pkg::value_t value_mem [cle_pkg::NODE_COUNT];

    logic [cle_pkg::NODE_COUNT-1:0] link_valid_reg;
    cle_pkg::node_t  free_reg;
    cle_pkg::node_t  first_reg;
    cle_pkg::node_t  link_rd_reg;
    cle_pkg::value_t value_rd_reg;
    cle_pkg::node_t  rd_addr_reg;
    logic            rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (wr.link_en)
        begin
            link_mem[wr.addr] <= wr.link;
        end
        if (wr.value_en)
        begin
            value_mem[wr.addr] <= wr.value;
        end
        link_rd_reg  <= link_mem[rd_addr];
        value_rd_reg <= value_mem[rd_addr];
        rd_valid_reg <= link_valid_reg[rd_addr];
        rd_addr_reg  <= rd_addr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            link_valid_reg <= '0;
            free_reg       <= cle_pkg::link_init(cle_pkg::FREE_NODE);
            first_reg      <= cle_pkg::link_init(cle_pkg::HEADER_NODE);
        end
        else if (wr.link_en)
        begin
            link_valid_reg[wr.addr] <= 1'b1;
            if (wr.addr == cle_pkg::FREE_NODE)
            begin
                free_reg <= wr.link;
            end
            if (wr.addr == cle_pkg::HEADER_NODE)
            begin
                first_reg <= wr.link;
            end
        end
    end

    // Both head links come from their registers so they see writes at once.
    always_comb
    begin
        if (rd_addr_reg == cle_pkg::FREE_NODE)
            link_rd = free_reg;
        else if (rd_addr_reg == cle_pkg::HEADER_NODE)
            link_rd = first_reg;
        else if (rd_valid_reg)
            link_rd = link_rd_reg;
        else
            link_rd = cle_pkg::link_init(rd_addr_reg);
    end

    assign value_rd   = value_rd_reg;
    assign free_head  = free_reg;
    assign first_node = first_reg;

endmodule

// ===== sv/cle_ctrl.sv =====
// Request sequencer: walks and relinks the list through the node memory.
module cle_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    input  cle_pkg::req_t     req,
    output cle_pkg::node_t    rd_addr,
    input  cle_pkg::node_t    link_rd,
    input  cle_pkg::value_t   value_rd,
    input  cle_pkg::node_t    free_head,
    input  cle_pkg::node_t    first_node,
    output cle_pkg::node_wr_t wr,
    output logic              res_valid,
    input  logic              res_ready,
    output cle_pkg::resp_t    res
);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_INS_B = 4'd1;
    localparam logic [3:0] S_INS_C = 4'd2;
    localparam logic [3:0] S_INS_D = 4'd3;
    localparam logic [3:0] S_SEEK  = 4'd4;
    localparam logic [3:0] S_REM_1 = 4'd5;
    localparam logic [3:0] S_REM_2 = 4'd6;
    localparam logic [3:0] S_REM_3 = 4'd7;
    localparam logic [3:0] S_FIND  = 4'd8;
    localparam logic [3:0] S_EMP_1 = 4'd9;
    localparam logic [3:0] S_EMP_2 = 4'd10;
    localparam logic [3:0] S_EMP_3 = 4'd11;
    localparam logic [3:0] S_RESP  = 4'd12;

    logic [3:0]      state_reg, state_next;
    cle_pkg::step_t  steps_reg, steps_next;
    logic [2:0]      op_reg, op_next;
    cle_pkg::value_t val_reg, val_next;
    cle_pkg::node_t  pos_reg, pos_next;
    cle_pkg::node_t  cur_reg, cur_next;
    cle_pkg::node_t  nx_reg, nx_next;
    cle_pkg::node_t  t_reg, t_next;
    cle_pkg::node_t  tl_reg, tl_next;
    cle_pkg::node_t  res_node_reg, res_node_next;
    logic            found_reg, found_next;
    logic [1:0]      status_reg, status_next;

    logic            hit;
    cle_pkg::step_t  steps_inc;

    assign hit       = (value_rd == val_reg);
    assign steps_inc = steps_reg + cle_pkg::STEP_W'(1);

    always_comb
    begin
        state_next    = state_reg;
        steps_next    = steps_reg;
        op_next       = op_reg;
        val_next      = val_reg;
        pos_next      = pos_reg;
        cur_next      = cur_reg;
        nx_next       = nx_reg;
        t_next        = t_reg;
        tl_next       = tl_reg;
        res_node_next = res_node_reg;
        found_next    = found_reg;
        status_next   = status_reg;
        rd_addr       = '0;
        wr            = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_valid)
                begin
                    op_next       = req.req_type;
                    val_next      = cle_pkg::VALUE_WIDTH'(req.value);
                    pos_next      = cle_pkg::NODE_W'(req.position);
                    res_node_next = '0;
                    found_next    = 1'b0;
                    status_next   = cle_pkg::ST_DONE;
                    steps_next    = '0;
                    state_next    = S_RESP;
                    case (req.req_type)
                        cle_pkg::REQ_INSERT:
                        begin
                            if (req.position == 7'd0 ||
                                32'(req.position) >= cle_pkg::NODE_COUNT)
                            begin
                                status_next = cle_pkg::ST_POS_ZERO;
                            end
                            else if (free_head == '0)
                            begin
                                status_next = cle_pkg::ST_FULL;
                            end
                            else
                            begin
                                t_next     = free_head;
                                rd_addr    = free_head;
                                state_next = S_INS_B;
                            end
                        end
                        cle_pkg::REQ_REMOVE, cle_pkg::REQ_PREV:
                        begin
                            cur_next = cle_pkg::HEADER_NODE;
                            nx_next  = first_node;
                            if (first_node == '0)
                            begin
                                status_next = cle_pkg::ST_NOT_FOUND;
                                if (req.req_type == cle_pkg::REQ_PREV)
                                begin
                                    res_node_next = cle_pkg::HEADER_NODE;
                                end
                            end
                            else
                            begin
                                rd_addr    = first_node;
                                state_next = S_SEEK;
                            end
                        end
                        cle_pkg::REQ_FIND:
                        begin
                            cur_next = first_node;
                            if (first_node == '0)
                            begin
                                status_next = cle_pkg::ST_NOT_FOUND;
                            end
                            else
                            begin
                                rd_addr    = first_node;
                                state_next = S_FIND;
                            end
                        end
                        cle_pkg::REQ_EMPTY:
                        begin
                            if (first_node != '0)
                            begin
                                t_next     = first_node;
                                rd_addr    = first_node;
                                state_next = S_EMP_1;
                            end
                        end
                        default:
                        begin
                            state_next = S_RESP;
                        end
                    endcase
                end
            end

            // Unlink the head of the free list, then fetch the link after position.
            S_INS_B:
            begin
                wr.link_en = 1'b1;
                wr.addr    = cle_pkg::FREE_NODE;
                wr.link    = link_rd;
                rd_addr    = pos_reg;
                state_next = S_INS_C;
            end

            S_INS_C:
            begin
                wr.link_en  = 1'b1;
                wr.value_en = 1'b1;
                wr.addr     = t_reg;
                wr.link     = link_rd;
                wr.value    = val_reg;
                state_next  = S_INS_D;
            end

            S_INS_D:
            begin
                wr.link_en    = 1'b1;
                wr.addr       = pos_reg;
                wr.link       = t_reg;
                res_node_next = t_reg;
                state_next    = S_RESP;
            end

            // cur_reg is the node before nx_reg, whose link and value are on the read port.
            S_SEEK:
            begin
                if (hit)
                begin
                    found_next = 1'b1;
                    if (op_reg == cle_pkg::REQ_PREV)
                    begin
                        res_node_next = cur_reg;
                        state_next    = S_RESP;
                    end
                    else
                    begin
                        t_next     = nx_reg;
                        tl_next    = link_rd;
                        state_next = S_REM_1;
                    end
                end
                else
                begin
                    cur_next   = nx_reg;
                    nx_next    = link_rd;
                    steps_next = steps_inc;
                    if (steps_inc == cle_pkg::STEP_LIMIT || link_rd == '0)
                    begin
                        status_next = cle_pkg::ST_NOT_FOUND;
                        if (op_reg == cle_pkg::REQ_PREV)
                        begin
                            res_node_next = nx_reg;
                        end
                        state_next = S_RESP;
                    end
                    else
                    begin
                        rd_addr = link_rd;
                    end
                end
            end

            S_REM_1:
            begin
                wr.link_en = 1'b1;
                wr.addr    = cur_reg;
                wr.link    = tl_reg;
                state_next = S_REM_2;
            end

            S_REM_2:
            begin
                wr.link_en = 1'b1;
                wr.addr    = t_reg;
                wr.link    = free_head;
                state_next = S_REM_3;
            end

            S_REM_3:
            begin
                wr.link_en    = 1'b1;
                wr.addr       = cle_pkg::FREE_NODE;
                wr.link       = t_reg;
                res_node_next = t_reg;
                state_next    = S_RESP;
            end

            S_FIND:
            begin
                if (hit)
                begin
                    found_next    = 1'b1;
                    res_node_next = cur_reg;
                    state_next    = S_RESP;
                end
                else
                begin
                    cur_next   = link_rd;
                    steps_next = steps_inc;
                    if (steps_inc == cle_pkg::STEP_LIMIT || link_rd == '0)
                    begin
                        status_next = cle_pkg::ST_NOT_FOUND;
                        state_next  = S_RESP;
                    end
                    else
                    begin
                        rd_addr = link_rd;
                    end
                end
            end

            S_EMP_1:
            begin
                wr.link_en = 1'b1;
                wr.addr    = cle_pkg::HEADER_NODE;
                wr.link    = link_rd;
                state_next = S_EMP_2;
            end

            S_EMP_2:
            begin
                wr.link_en = 1'b1;
                wr.addr    = t_reg;
                wr.link    = free_head;
                state_next = S_EMP_3;
            end

            // Push the freed node and start on the next one in the same cycle.
            S_EMP_3:
            begin
                wr.link_en = 1'b1;
                wr.addr    = cle_pkg::FREE_NODE;
                wr.link    = t_reg;
                steps_next = steps_inc;
                if (first_node == '0 || steps_inc == cle_pkg::STEP_LIMIT)
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    t_next     = first_node;
                    rd_addr    = first_node;
                    state_next = S_EMP_1;
                end
            end

            S_RESP:
            begin
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            steps_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            steps_reg <= steps_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        val_reg      <= val_next;
        pos_reg      <= pos_next;
        cur_reg      <= cur_next;
        nx_reg       <= nx_next;
        t_reg        <= t_next;
        tl_reg       <= tl_next;
        res_node_reg <= res_node_next;
        found_reg    <= found_next;
        status_reg   <= status_next;
    end

    assign req_ready       = (state_reg == S_IDLE);
    assign res_valid       = (state_reg == S_RESP);
    assign res.result_node = 7'(res_node_reg);
    assign res.found       = found_reg;
    assign res.list_empty  = (first_node == '0);
    assign res.first_node  = 7'(first_node);
    assign res.status      = status_reg;

    a_found_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && found_reg |-> status_reg == cle_pkg::ST_DONE)
        else $error("found set on a failed request");

    a_insert_node: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && op_reg == cle_pkg::REQ_INSERT && status_reg == cle_pkg::ST_DONE
        |-> res_node_reg != '0)
        else $error("insert done without a node");

    a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
        steps_reg <= cle_pkg::STEP_LIMIT)
        else $error("walk ran past the node count");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready |=> state_reg != S_IDLE)
        else $error("accepted request left the sequencer idle");

endmodule

// ===== sv/cursor_list_engine_core.sv =====
// Top level of the cursor list engine: stream ports, sequencer, node memory, output register.
//
// Keeps one singly linked list in a 128-node memory; node 0 heads the free list and
// node 1 is the list header. One request is taken at a time and gives one result.
// Insert with position zero or a full free list, and unused codes, go straight to the
// result without touching the node memory. Find, find previous and remove walk the
// list one node per read, for up to 128 nodes; remove then writes three links. Make
// empty frees the nodes one at a time, with three link writes for each. The node memory
// has a single read and a single write port, and the walk reads one link per cycle.
// A new request is taken while a result still waits on the master side; after reset
// the engine is ready at once.
module cursor_list_engine_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // value[31:0], position[38:32], zero pad
    input  logic [2:0]  s_tuser,   // req_type[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata    // result_node[6:0], found, list_empty, first_node[15:9],
                                   // status[17:16], zero pad
);

    cle_pkg::req_t     req;
    cle_pkg::resp_t    res;
    cle_pkg::node_t    rd_addr;
    cle_pkg::node_t    link_rd;
    cle_pkg::value_t   value_rd;
    cle_pkg::node_t    free_head;
    cle_pkg::node_t    first_node;
    cle_pkg::node_wr_t wr;
    logic              res_valid;
    logic              res_ready;

    logic              m_valid_reg;
    logic [23:0]       m_data_reg;

    assign req.req_type = s_tuser;
    assign req.value    = s_tdata[31:0];
    assign req.position = s_tdata[38:32];

    cle_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .req_valid  (s_tvalid),
        .req_ready  (s_tready),
        .req        (req),
        .rd_addr    (rd_addr),
        .link_rd    (link_rd),
        .value_rd   (value_rd),
        .free_head  (free_head),
        .first_node (first_node),
        .wr         (wr),
        .res_valid  (res_valid),
        .res_ready  (res_ready),
        .res        (res)
    );

    cle_node_mem u_mem
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .rd_addr    (rd_addr),
        .link_rd    (link_rd),
        .value_rd   (value_rd),
        .wr         (wr),
        .free_head  (free_head),
        .first_node (first_node)
    );

    // Hold the finished transaction until the master side takes it.
    assign res_ready = !m_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
        begin
            m_data_reg <= {6'd0, res.status, res.first_node, res.list_empty,
                           res.found, res.result_node};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
